### hdl/rpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants of the rectangular/polar converter
// Formats, pipeline sizing, arctangent constants and the structs passed
// between the datapath pipeline and the stream wrapper.
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int DATA_WIDTH = 16;   // coordinates and magnitude, Q8
  localparam int ANG_WIDTH  = 16;   // angle in and out, Q13 radians
  localparam int ITERATIONS = 16;   // CORDIC micro-rotations
  localparam int TABLE_LEN  = 24;

  localparam int CORDIC_STEPS = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
  localparam int SQRT_STEPS   = DATA_WIDTH;
  localparam int NSTG = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;

  localparam int XW = DATA_WIDTH + 19;   // CORDIC x/y datapath
  localparam int ZW = 21;                // angle accumulator, Q16 radians
  localparam int SW = 2 * DATA_WIDTH;    // sum of squares / root remainder
  localparam int PW = DATA_WIDTH + 16;   // magnitude times gain

  localparam int IN_W    = 3 * DATA_WIDTH + ANG_WIDTH;
  localparam int TDATA_W = ((IN_W + 7) / 8) * 8;

  localparam logic signed [ZW-1:0] PI_Z       = ZW'(205887);
  localparam logic signed [ZW-1:0] HALF_PI_Z  = ZW'(102944);
  localparam logic signed [ZW-1:0] ANG_LIM    = ZW'(25736);
  localparam logic [15:0]          GAIN_Q16   = 16'd39797;
  localparam int                   VEC_SHIFT  = 14;

  typedef enum logic {
    ACT_P2R = 1'b0,
    ACT_R2P = 1'b1
  } rpc_action_e;

  typedef struct packed {
    rpc_action_e                   action;
    logic signed [DATA_WIDTH-1:0]  coord_x;
    logic signed [DATA_WIDTH-1:0]  coord_y;
    logic        [DATA_WIDTH-1:0]  magnitude;
    logic signed [ANG_WIDTH-1:0]   angle;
  } rpc_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]  out_x;
    logic signed [DATA_WIDTH-1:0]  out_y;
    logic        [DATA_WIDTH-1:0]  out_magnitude;
    logic signed [ANG_WIDTH-1:0]   out_angle;
    logic                          saturated;
  } rpc_res_t;

  typedef struct packed {
    logic     valid;
    rpc_res_t res;
  } rpc_pipe_out_t;

  // arctangent of 2^-i, Q16 radians
  function automatic logic signed [ZW-1:0] atan_q16(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:       v = ZW'(51472);
      1:       v = ZW'(30386);
      2:       v = ZW'(16055);
      3:       v = ZW'(8150);
      4:       v = ZW'(4091);
      5:       v = ZW'(2047);
      6:       v = ZW'(1024);
      7:       v = ZW'(512);
      8:       v = ZW'(256);
      9:       v = ZW'(128);
      10:      v = ZW'(64);
      11:      v = ZW'(32);
      12:      v = ZW'(16);
      13:      v = ZW'(8);
      14:      v = ZW'(4);
      15:      v = ZW'(2);
      16:      v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### hdl/rect_polar_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rect_polar_converter: CORDIC rectangular/polar coordinate converter
// Stream wrapper around the converter pipeline with an output skid stage.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out, in order. tuser selects the
// action: 1 turns (x, y) into magnitude and atan2 angle, 0 turns magnitude
// and angle into saturated (x, y). A new item is taken every cycle while the
// skid stage is empty; a result passes through the setup stage, 16 stages of
// combined CORDIC micro-rotation and square-root digit, the finishing stage
// and the output register. The skid stage decouples the input from the output
// ready, so one more item drains into it when the output stalls.
module rect_polar_converter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // coord_x, coord_y, magnitude, angle
  input  logic [rpc_pkg::TDATA_W-1:0] s_axis_tdata,
  // action
  input  logic                        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // out_x, out_y, out_magnitude, out_angle
  output logic [rpc_pkg::TDATA_W-1:0] m_axis_tdata,
  // saturated
  output logic                        m_axis_tuser
);
  import rpc_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int AW = ANG_WIDTH;

  rpc_in_t       in_item;
  rpc_pipe_out_t pipe_out;
  rpc_res_t      out_d, out_q, skid_d, skid_q;
  logic          out_vld_d, out_vld_q, skid_vld_d, skid_vld_q;
  logic          adv, out_xfer;

  always_comb begin
    in_item.action    = rpc_action_e'(s_axis_tuser);
    in_item.coord_x   = s_axis_tdata[DW-1:0];
    in_item.coord_y   = s_axis_tdata[2*DW-1:DW];
    in_item.magnitude = s_axis_tdata[3*DW-1:2*DW];
    in_item.angle     = s_axis_tdata[3*DW+AW-1:3*DW];
  end

  assign adv           = !skid_vld_q;
  assign s_axis_tready = adv;

  rpc_pipe u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .in_valid_i (s_axis_tvalid),
    .in_i       (in_item),
    .out_o      (pipe_out)
  );

  assign out_xfer = out_vld_q && m_axis_tready;

  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (adv) begin
      if (!out_vld_q || out_xfer) begin
        out_d     = pipe_out.res;
        out_vld_d = pipe_out.valid;
      end else if (pipe_out.valid) begin
        skid_d     = pipe_out.res;
        skid_vld_d = 1'b1;
      end
    end else if (out_xfer) begin
      // pipeline frozen: drain the skid entry into the output register
      out_d      = skid_q;
      skid_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = TDATA_W'({out_q.out_angle, out_q.out_magnitude,
                                   out_q.out_y, out_q.out_x});
  assign m_axis_tuser  = out_q.saturated;

  // skid entry only exists behind a held output
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry without output entry");

  // skid entry is kept until the output drains
  a_skid_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && !m_axis_tready |=> skid_vld_q && $stable(skid_q))
    else $error("skid entry lost during output stall");

  // clipping only comes from the polar-to-rectangular action
  a_sat_p2r_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.saturated |-> out_q.out_magnitude == '0 && out_q.out_angle == '0)
    else $error("saturated flag on a polar result");

  // a nonzero magnitude is a rectangular-to-polar result
  a_mag_r2p_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.out_magnitude != '0 |->
      out_q.out_x == '0 && out_q.out_y == '0 && !out_q.saturated)
    else $error("coordinate fields set on a polar result");

endmodule
`default_nettype wire

### hdl/rpc_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpc_pipe: converter datapath pipeline
// Setup stage (multipliers, quadrant fold), one register stage per CORDIC
// micro-rotation and root digit, and a finishing stage; the final rounding
// and clipping is left combinational for the output register.
// ----------------------------------------------------------------------------
module rpc_pipe (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  in_valid_i,
  input  rpc_pkg::rpc_in_t      in_i,
  output rpc_pkg::rpc_pipe_out_t out_o
);
  import rpc_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int AW = ANG_WIDTH;

  typedef struct packed {
    rpc_action_e          act;
    logic                 flip;
    logic                 zero;
    logic signed [XW-1:0] cx;
    logic signed [XW-1:0] cy;
    logic signed [ZW-1:0] z;
    logic        [SW-1:0] sqx;
    logic        [SW-1:0] sqy;
  } pre_t;

  typedef struct packed {
    rpc_action_e          act;
    logic                 flip;
    logic                 zero;
    logic signed [XW-1:0] cx;
    logic signed [XW-1:0] cy;
    logic signed [ZW-1:0] z;
    logic        [SW-1:0] n;
    logic        [SW-1:0] r;
  } stg_t;

  typedef struct packed {
    rpc_action_e          act;
    logic                 zero;
    logic signed [XW-1:0] vx;
    logic signed [XW-1:0] vy;
    logic        [DW-1:0] mag;
    logic signed [ZW-1:0] ang;
  } post_t;

  localparam logic signed [XW-1:0] RND_HALF = XW'(32768);
  localparam logic signed [XW-1:0] CLIP_HI  = XW'((64'd1 << (DW - 1)) - 64'd1);
  localparam logic signed [XW-1:0] CLIP_LO  = ~CLIP_HI;

  // ---------------- setup stage ----------------
  pre_t                  pre_d, pre_q;
  logic                  pre_vld_q;
  logic signed [ZW-1:0]  z_in;
  logic signed [XW-1:0]  vec_x, vec_y;
  logic        [DW-1:0]  abs_x, abs_y;
  logic        [PW-1:0]  prod;

  always_comb begin
    z_in  = {{(ZW-AW-3){in_i.angle[AW-1]}}, in_i.angle, 3'b000};
    vec_x = XW'(in_i.coord_x) <<< VEC_SHIFT;
    vec_y = XW'(in_i.coord_y) <<< VEC_SHIFT;
    abs_x = in_i.coord_x[DW-1] ? DW'(-in_i.coord_x) : DW'(in_i.coord_x);
    abs_y = in_i.coord_y[DW-1] ? DW'(-in_i.coord_y) : DW'(in_i.coord_y);
    prod  = PW'(in_i.magnitude) * PW'(GAIN_Q16);

    pre_d.act  = in_i.action;
    pre_d.zero = (in_i.coord_x == '0) && (in_i.coord_y == '0);
    pre_d.sqx  = SW'(abs_x) * SW'(abs_x);
    pre_d.sqy  = SW'(abs_y) * SW'(abs_y);
    pre_d.flip = 1'b0;
    if (in_i.action == ACT_R2P) begin
      // left half-plane: rotate by a half turn, start the angle at +/- pi
      if (in_i.coord_x[DW-1]) begin
        pre_d.cx = -vec_x;
        pre_d.cy = -vec_y;
        pre_d.z  = in_i.coord_y[DW-1] ? -PI_Z : PI_Z;
      end else begin
        pre_d.cx = vec_x;
        pre_d.cy = vec_y;
        pre_d.z  = '0;
      end
    end else begin
      pre_d.cx = XW'(prod);
      pre_d.cy = '0;
      pre_d.z  = z_in;
      if (z_in > HALF_PI_Z) begin
        pre_d.z    = z_in - PI_Z;
        pre_d.flip = 1'b1;
      end else if (z_in < -HALF_PI_Z) begin
        pre_d.z    = z_in + PI_Z;
        pre_d.flip = 1'b1;
      end
    end
  end

  // ---------------- iteration stages ----------------
  stg_t stg_cur [NSTG];
  stg_t stg_d   [NSTG];
  stg_t stg_q   [NSTG];
  logic [NSTG-1:0] stg_vld_q;

  always_comb begin
    stg_cur[0].act  = pre_q.act;
    stg_cur[0].flip = pre_q.flip;
    stg_cur[0].zero = pre_q.zero;
    stg_cur[0].cx   = pre_q.cx;
    stg_cur[0].cy   = pre_q.cy;
    stg_cur[0].z    = pre_q.z;
    stg_cur[0].n    = pre_q.sqx + pre_q.sqy;
    stg_cur[0].r    = '0;
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    logic signed [XW-1:0] nx, ny;
    logic signed [ZW-1:0] nz;
    logic        [SW-1:0] nn, nr;

    if (k > 0) begin : g_link
      assign stg_cur[k] = stg_q[k-1];
    end

    if (k < CORDIC_STEPS) begin : g_rot
      localparam logic signed [ZW-1:0] AT = atan_q16(k);
      logic signed [XW-1:0] xs, ys;
      logic                 d_pos;
      always_comb begin
        xs    = stg_cur[k].cx >>> k;
        ys    = stg_cur[k].cy >>> k;
        // vectoring drives y toward zero, rotation drives z toward zero
        d_pos = (stg_cur[k].act == ACT_R2P) ? stg_cur[k].cy[XW-1] : !stg_cur[k].z[ZW-1];
        if (d_pos) begin
          nx = stg_cur[k].cx - ys;
          ny = stg_cur[k].cy + xs;
          nz = stg_cur[k].z - AT;
        end else begin
          nx = stg_cur[k].cx + ys;
          ny = stg_cur[k].cy - xs;
          nz = stg_cur[k].z + AT;
        end
      end
    end else begin : g_rot_idle
      assign nx = stg_cur[k].cx;
      assign ny = stg_cur[k].cy;
      assign nz = stg_cur[k].z;
    end

    if (k < SQRT_STEPS) begin : g_root
      localparam logic [SW:0] SQ_BIT = (SW+1)'(1) << (SW - 2 - 2 * k);
      logic [SW:0] trial;
      always_comb begin
        trial = {1'b0, stg_cur[k].r} + SQ_BIT;
        if ({1'b0, stg_cur[k].n} >= trial) begin
          nn = stg_cur[k].n - trial[SW-1:0];
          nr = (stg_cur[k].r >> 1) + SQ_BIT[SW-1:0];
        end else begin
          nn = stg_cur[k].n;
          nr = stg_cur[k].r >> 1;
        end
      end
    end else begin : g_root_idle
      assign nn = stg_cur[k].n;
      assign nr = stg_cur[k].r;
    end

    always_comb begin
      stg_d[k]    = stg_cur[k];
      stg_d[k].cx = nx;
      stg_d[k].cy = ny;
      stg_d[k].z  = nz;
      stg_d[k].n  = nn;
      stg_d[k].r  = nr;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  // ---------------- finishing stage ----------------
  post_t post_d, post_q;
  logic  post_vld_q;
  stg_t  last;

  always_comb begin
    last        = stg_q[NSTG-1];
    post_d.act  = last.act;
    post_d.zero = last.zero;
    post_d.vx   = last.flip ? -last.cx : last.cx;
    post_d.vy   = last.flip ? -last.cy : last.cy;
    // remainder above the root means the half-up rounding goes up
    post_d.mag  = (last.n > last.r) ? DW'(last.r) + DW'(1) : DW'(last.r);
    post_d.ang  = (last.z + ZW'(4)) >>> 3;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_q  <= pre_d;
      post_q <= post_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q  <= 1'b0;
      stg_vld_q  <= '0;
      post_vld_q <= 1'b0;
    end else if (en_i) begin
      pre_vld_q  <= in_valid_i;
      stg_vld_q  <= {stg_vld_q[NSTG-2:0], pre_vld_q};
      post_vld_q <= stg_vld_q[NSTG-1];
    end
  end

  // ---------------- output rounding and clipping ----------------
  logic signed [XW-1:0] rnd_x, rnd_y;
  logic signed [ZW-1:0] ang_c;
  logic                 sat_x, sat_y;

  always_comb begin
    rnd_x = (post_q.vx + RND_HALF) >>> 16;
    rnd_y = (post_q.vy + RND_HALF) >>> 16;
    sat_x = (rnd_x > CLIP_HI) || (rnd_x < CLIP_LO);
    sat_y = (rnd_y > CLIP_HI) || (rnd_y < CLIP_LO);

    if (post_q.zero) begin
      ang_c = '0;
    end else if (post_q.ang > ANG_LIM) begin
      ang_c = ANG_LIM;
    end else if (post_q.ang < -ANG_LIM) begin
      ang_c = -ANG_LIM;
    end else begin
      ang_c = post_q.ang;
    end

    out_o.valid = post_vld_q;
    if (post_q.act == ACT_R2P) begin
      out_o.res.out_x         = '0;
      out_o.res.out_y         = '0;
      out_o.res.saturated     = 1'b0;
      out_o.res.out_magnitude = post_q.mag;
      out_o.res.out_angle     = ang_c[AW-1:0];
    end else begin
      out_o.res.out_x = (rnd_x > CLIP_HI) ? CLIP_HI[DW-1:0] :
                        (rnd_x < CLIP_LO) ? CLIP_LO[DW-1:0] : rnd_x[DW-1:0];
      out_o.res.out_y = (rnd_y > CLIP_HI) ? CLIP_HI[DW-1:0] :
                        (rnd_y < CLIP_LO) ? CLIP_LO[DW-1:0] : rnd_y[DW-1:0];
      out_o.res.saturated     = sat_x || sat_y;
      out_o.res.out_magnitude = '0;
      out_o.res.out_angle     = '0;
    end
  end

endmodule
`default_nettype wire

### sim/tb_rect_polar_converter.sv
// ----------------------------------------------------------------------------
// tb_rect_polar_converter: self-checking bench for the coordinate converter
// Streams directed corner cases and random conversions of both actions into
// the block. A bit-accurate CORDIC and square-root predictor computes each
// expected result, and every output transfer is checked field by field in
// order. The first two of three phases apply backpressure and input gaps.
// ----------------------------------------------------------------------------
module tb_rect_polar_converter;
  import rpc_pkg::*;

  localparam int RANDOM_PER_PHASE = 430;
  localparam int DRAIN_CYCLES     = 40;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [TDATA_W-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]  m_axis_tdata;
  logic                m_axis_tuser;

  rpc_in_t  pending_q[$];
  rpc_res_t expected_q[$];
  int       src_idle_pct = 0;
  int       sink_idle_pct = 0;
  int       err_count = 0;
  logic     in_taken = 1'b0;
  rpc_in_t  drive_item;
  rpc_in_t  seen_item;
  rpc_res_t want;
  rpc_res_t got;

  // atan(2^-i) in Q16 radians
  longint atan_q16_tab [24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                256, 128, 64, 32, 16, 8, 4, 2,
                                1, 0, 0, 0, 0, 0, 0, 0};

  rect_polar_converter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic rpc_res_t convert(input rpc_in_t it);
    rpc_res_t r;
    longint   x, y, cx, cy, nx, ny, z, ang, sq, root, rem_v, bitv, rx, ry, lim;
    bit       flip, sat;
    r = '0;
    lim = (longint'(1) << (DATA_WIDTH - 1)) - 1;
    if (it.action == ACT_R2P) begin
      x = longint'(it.coord_x);
      y = longint'(it.coord_y);
      sq = x * x + y * y;
      // bitwise integer square root, then round half up
      root = 0;
      rem_v = sq;
      bitv = longint'(1) << 40;
      while (bitv > rem_v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rem_v >= root + bitv) begin
          rem_v = rem_v - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      if (sq - root * root > root) root = root + 1;
      if (root > (longint'(1) << DATA_WIDTH) - 1) root = (longint'(1) << DATA_WIDTH) - 1;
      z = 0;
      if (x != 0 || y != 0) begin
        cx = x * 16384;
        cy = y * 16384;
        if (x < 0) begin
          z = (y >= 0) ? longint'(PI_Z) : -longint'(PI_Z);
          cx = -cx;
          cy = -cy;
        end
        for (int i = 0; i < ITERATIONS && i < 24; i++) begin
          if (cy >= 0) begin
            nx = cx + (cy >>> i);
            ny = cy - (cx >>> i);
            z = z + atan_q16_tab[i];
          end else begin
            nx = cx - (cy >>> i);
            ny = cy + (cx >>> i);
            z = z - atan_q16_tab[i];
          end
          cx = nx;
          cy = ny;
        end
      end
      ang = (z + 4) >>> 3;
      if (ang > longint'(ANG_LIM)) ang = longint'(ANG_LIM);
      if (ang < -longint'(ANG_LIM)) ang = -longint'(ANG_LIM);
      r.out_magnitude = root[DATA_WIDTH-1:0];
      r.out_angle = ang[ANG_WIDTH-1:0];
    end else begin
      z = longint'(it.angle) * 8;
      cx = longint'({1'b0, it.magnitude}) * longint'({1'b0, GAIN_Q16});
      cy = 0;
      flip = 1'b0;
      sat = 1'b0;
      // single half-turn fold
      if (z > longint'(HALF_PI_Z)) begin
        z = z - longint'(PI_Z);
        flip = 1'b1;
      end else if (z < -longint'(HALF_PI_Z)) begin
        z = z + longint'(PI_Z);
        flip = 1'b1;
      end
      for (int i = 0; i < ITERATIONS && i < 24; i++) begin
        if (z >= 0) begin
          nx = cx - (cy >>> i);
          ny = cy + (cx >>> i);
          z = z - atan_q16_tab[i];
        end else begin
          nx = cx + (cy >>> i);
          ny = cy - (cx >>> i);
          z = z + atan_q16_tab[i];
        end
        cx = nx;
        cy = ny;
      end
      if (flip) begin
        cx = -cx;
        cy = -cy;
      end
      rx = (cx + 32768) >>> 16;
      ry = (cy + 32768) >>> 16;
      if (rx > lim) begin rx = lim; sat = 1'b1; end
      if (rx < -lim - 1) begin rx = -lim - 1; sat = 1'b1; end
      if (ry > lim) begin ry = lim; sat = 1'b1; end
      if (ry < -lim - 1) begin ry = -lim - 1; sat = 1'b1; end
      r.out_x = rx[DATA_WIDTH-1:0];
      r.out_y = ry[DATA_WIDTH-1:0];
      r.saturated = sat;
    end
    return r;
  endfunction

  function automatic rpc_in_t random_conversion();
    rpc_in_t it;
    it.action = rpc_action_e'($urandom_range(0, 1));
    it.coord_x = 16'($urandom);
    it.coord_y = 16'($urandom);
    it.magnitude = 16'($urandom);
    it.angle = 16'($urandom);
    if (it.action == ACT_R2P) begin
      if ($urandom_range(0, 4) == 0) begin
        it.coord_x = 16'($urandom_range(0, 64) - 32);
        it.coord_y = 16'($urandom_range(0, 64) - 32);
      end
    end else begin
      case ($urandom_range(0, 9))
        0: it.magnitude = 16'($urandom_range(0, 300));
        1: ;  // full-range magnitude and angle
        default: begin
          it.magnitude = 16'($urandom_range(0, 46341));
          it.angle = 16'($urandom_range(0, 51472) - 25736);
        end
      endcase
    end
    return it;
  endfunction

  task automatic queue_conversion(input rpc_action_e act, input int x, input int y,
                                  input int mag, input int ang);
    rpc_in_t it;
    it.action = act;
    it.coord_x = 16'(x);
    it.coord_y = 16'(y);
    it.magnitude = 16'(mag);
    it.angle = 16'(ang);
    pending_q.push_back(it);
  endtask

  task automatic report_mismatch(input string field, input int exp_v, input int got_v);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, field, exp_v, got_v);
    err_count++;
  endtask

  // driver: present a new transfer once the previous one has been taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          drive_item = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {drive_item.angle, drive_item.magnitude,
                           drive_item.coord_y, drive_item.coord_x};
          s_axis_tuser <= drive_item.action;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // monitor: predict on input transfers, check output transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        seen_item.action = rpc_action_e'(s_axis_tuser);
        seen_item.coord_x = s_axis_tdata[15:0];
        seen_item.coord_y = s_axis_tdata[31:16];
        seen_item.magnitude = s_axis_tdata[47:32];
        seen_item.angle = s_axis_tdata[63:48];
        expected_q.push_back(convert(seen_item));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.out_x = m_axis_tdata[15:0];
        got.out_y = m_axis_tdata[31:16];
        got.out_magnitude = m_axis_tdata[47:32];
        got.out_angle = m_axis_tdata[63:48];
        got.saturated = m_axis_tuser;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transfer", 0, 1);
        end else begin
          want = expected_q.pop_front();
          if (got.out_x !== want.out_x)
            report_mismatch("out_x", int'(want.out_x), int'(got.out_x));
          if (got.out_y !== want.out_y)
            report_mismatch("out_y", int'(want.out_y), int'(got.out_y));
          if (got.out_magnitude !== want.out_magnitude)
            report_mismatch("out_magnitude", int'(want.out_magnitude),
                            int'(got.out_magnitude));
          if (got.out_angle !== want.out_angle)
            report_mismatch("out_angle", int'(want.out_angle), int'(got.out_angle));
          if (got.saturated !== want.saturated)
            report_mismatch("saturated", int'(want.saturated), int'(got.saturated));
        end
      end
    end
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // rectangular to polar corners: zero vector, axes, diagonals, negative x
    queue_conversion(ACT_R2P, 0, 0, 0, 0);
    queue_conversion(ACT_R2P, 32767, 0, 0, 0);
    queue_conversion(ACT_R2P, -32768, 0, 0, 0);
    queue_conversion(ACT_R2P, 0, 32767, 0, 0);
    queue_conversion(ACT_R2P, 0, -32768, 0, 0);
    queue_conversion(ACT_R2P, 32767, 32767, 0, 0);
    queue_conversion(ACT_R2P, -32768, -32768, 0, 0);
    queue_conversion(ACT_R2P, -32768, 32767, 0, 0);
    queue_conversion(ACT_R2P, -1, 0, 0, 0);
    queue_conversion(ACT_R2P, -1, -1, 0, 0);
    queue_conversion(ACT_R2P, 256, 256, 0, 0);
    // polar to rectangular: zero, range limits, fold edges, saturation
    queue_conversion(ACT_P2R, 0, 0, 0, 0);
    queue_conversion(ACT_P2R, 0, 0, 46341, 0);
    queue_conversion(ACT_P2R, 0, 0, 65535, 0);
    queue_conversion(ACT_P2R, 0, 0, 46341, 25736);
    queue_conversion(ACT_P2R, 0, 0, 46341, -25736);
    queue_conversion(ACT_P2R, 0, 0, 46341, 32767);
    queue_conversion(ACT_P2R, 0, 0, 46341, -32768);
    queue_conversion(ACT_P2R, 0, 0, 25600, 12868);
    queue_conversion(ACT_P2R, 0, 0, 25600, 12869);
    queue_conversion(ACT_P2R, 0, 0, 25600, -12869);
    queue_conversion(ACT_P2R, 0, 0, 65535, 6434);
    queue_conversion(ACT_P2R, 0, 0, 65535, -19302);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle_pct = 6;  sink_idle_pct = 85; end
        1: begin src_idle_pct = 85; sink_idle_pct = 6;  end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) pending_q.push_back(random_conversion());
      while (pending_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    end

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS rect_polar_converter");
    end else begin
      $display("FAIL rect_polar_converter");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("FAIL rect_polar_converter");
    $finish;
  end

endmodule

### sim.f
hdl/rpc_pkg.sv
hdl/rpc_pipe.sv
hdl/rect_polar_converter.sv
sim/tb_rect_polar_converter.sv
